### hw/rtl/mccd_pkg.sv
// Package for the minimum-coin change block: sizes, payload words, FSM states,
// and the take-cost helper.
// No dependencies.
package mccd_pkg;

  localparam int MaxCoins  = 64;
  localparam int MaxSum    = 63;
  localparam int IdxW      = $clog2(MaxCoins);
  localparam int CntW      = IdxW + 1;
  localparam int SumW      = $clog2(MaxSum + 1);
  localparam int CoinW     = 16;
  localparam int TabW      = 7;
  localparam int TabAddrW  = IdxW + SumW;
  localparam logic [TabW-1:0] CountInf = 7'd127;

  typedef struct packed {
    logic [CoinW-1:0] coin_value;
    logic             last_coin;
  } in_word_t;

  typedef struct packed {
    logic [CoinW-1:0] chosen_value;
    logic             found;
    logic             last_result;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SA, S_SAW, S_SB, S_SBW, S_SW1, S_SW2,
    S_FC, S_FCW, S_FRD, S_FWR, S_CHK, S_CHKW,
    S_WC, S_WCW, S_WRD, S_WDEC, S_NF
  } state_t;

  // Count for one more use of coin c at sum s, given the entry at s - c.
  function automatic logic [TabW-1:0] take_cost(logic [CoinW-1:0] c,
                                                logic [SumW-1:0] s,
                                                logic [TabW-1:0] v);
    logic [TabW-1:0] res;
    if (c == '0 || c > CoinW'(s) || v >= CountInf) res = CountInf;
    else res = v + TabW'(1);
    return res;
  endfunction

endpackage

### hw/rtl/min_coin_change_dp.sv
// Top level of the minimum-coin change block: control FSM, sort, table fill
// and walk-back. Depends on mccd_pkg, mccd_coin_ram, mccd_table_ram.
//
//  channel  | signals                      | moves
//  ---------+------------------------------+-------------------------------
//  in       | in_valid/in_ready, in_data   | one coin word per accept
//  out      | out_valid/out_ready,out_data | one result word per accept
//  cfg      | cfg_we, cfg_data             | target_sum, no wait
//
// Coins load while the FSM is idle, one per accept. Unless target_sum is zero,
// the final coin starts a selection sort in the coin RAM (one read port,
// skipped for a single coin), a table fill that reads then writes each entry,
// a reachability check and a walk-back: a word per coin taken, else a row down.
// Reset (rst, synchronous) clears the FSM and the coin count;
// the RAMs need no clearing. A stalled out word holds the walk in place.
module min_coin_change_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  mccd_pkg::in_word_t      in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mccd_pkg::out_word_t     out_data,
  input  logic                    cfg_we,
  input  logic [mccd_pkg::SumW-1:0] cfg_data
);
  localparam int IdxW = mccd_pkg::IdxW;
  localparam int CntW = mccd_pkg::CntW;
  localparam int SumW = mccd_pkg::SumW;
  localparam int CoinW = mccd_pkg::CoinW;
  localparam int TabW = mccd_pkg::TabW;

  mccd_pkg::state_t state, state_next;

  logic [SumW-1:0]  target_sum;
  logic [CntW-1:0]  coin_count;
  logic [CntW-1:0]  n;
  logic [IdxW-1:0]  a, b, best, r;
  logic [SumW-1:0]  s;
  logic [CoinW-1:0] aval, bestval, c;

  // memory ports
  logic             c_we;
  logic [IdxW-1:0]  c_waddr, c_raddr;
  logic [CoinW-1:0] c_wdata, c_rdata;
  logic             t_we;
  logic [mccd_pkg::TabAddrW-1:0] t_waddr, t_raddr_a, t_raddr_b;
  logic [TabW-1:0]  t_wdata, t_rdata_a, t_rdata_b;

  logic             in_acc, out_free;
  logic [CntW-1:0]  n_load;
  logic [TabW-1:0]  take, skip;
  logic [SumW-1:0]  s_rem;
  logic             take_ok;

  mccd_coin_ram u_coin (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  mccd_table_ram u_table (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr_a(t_raddr_a), .rdata_a(t_rdata_a),
    .raddr_b(t_raddr_b), .rdata_b(t_rdata_b)
  );

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign n_load   = (coin_count < CntW'(mccd_pkg::MaxCoins)) ? coin_count + CntW'(1)
                                                              : coin_count;
  assign s_rem    = s - c[SumW-1:0];
  assign take     = mccd_pkg::take_cost(c, s, t_rdata_b);
  assign skip     = (r == '0) ? mccd_pkg::CountInf : t_rdata_a;
  assign take_ok  = (take < mccd_pkg::CountInf) && (t_rdata_a == take);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mccd_pkg::S_IDLE:
        if (in_acc && in_data.last_coin) begin
          if (target_sum == '0) state_next = mccd_pkg::S_NF;
          else if (n_load >= CntW'(2)) state_next = mccd_pkg::S_SA;
          else state_next = mccd_pkg::S_FC;
        end
      mccd_pkg::S_SA:  state_next = mccd_pkg::S_SAW;
      mccd_pkg::S_SAW: state_next = mccd_pkg::S_SB;
      mccd_pkg::S_SB:  state_next = mccd_pkg::S_SBW;
      mccd_pkg::S_SBW:
        state_next = ({1'b0, b} + CntW'(1) < n) ? mccd_pkg::S_SB : mccd_pkg::S_SW1;
      mccd_pkg::S_SW1: state_next = mccd_pkg::S_SW2;
      mccd_pkg::S_SW2:
        state_next = ({1'b0, a} + CntW'(2) < n) ? mccd_pkg::S_SA : mccd_pkg::S_FC;
      mccd_pkg::S_FC:  state_next = mccd_pkg::S_FCW;
      mccd_pkg::S_FCW: state_next = mccd_pkg::S_FRD;
      mccd_pkg::S_FRD: state_next = mccd_pkg::S_FWR;
      mccd_pkg::S_FWR:
        if (s != target_sum) state_next = mccd_pkg::S_FRD;
        else if ({1'b0, r} + CntW'(1) < n) state_next = mccd_pkg::S_FC;
        else state_next = mccd_pkg::S_CHK;
      mccd_pkg::S_CHK:  state_next = mccd_pkg::S_CHKW;
      mccd_pkg::S_CHKW:
        state_next = (t_rdata_a >= mccd_pkg::CountInf) ? mccd_pkg::S_NF : mccd_pkg::S_WC;
      mccd_pkg::S_WC:  state_next = mccd_pkg::S_WCW;
      mccd_pkg::S_WCW: state_next = mccd_pkg::S_WRD;
      mccd_pkg::S_WRD: state_next = mccd_pkg::S_WDEC;
      mccd_pkg::S_WDEC:
        if (take_ok) begin
          if (out_free) state_next = (s_rem == '0) ? mccd_pkg::S_IDLE : mccd_pkg::S_WRD;
        end else begin
          state_next = (r == '0) ? mccd_pkg::S_IDLE : mccd_pkg::S_WC;
        end
      mccd_pkg::S_NF:
        if (out_free) state_next = mccd_pkg::S_IDLE;
      default: state_next = mccd_pkg::S_IDLE;
    endcase
  end

  // memory controls and ready
  always_comb begin
    in_ready  = (state == mccd_pkg::S_IDLE);
    c_we      = 1'b0;
    c_waddr   = coin_count[IdxW-1:0];
    c_wdata   = in_data.coin_value;
    c_raddr   = r;
    t_we      = 1'b0;
    t_waddr   = {r, s};
    t_wdata   = (take < skip) ? take : skip;
    t_raddr_a = {r, s};
    t_raddr_b = {r, s_rem};
    case (state)
      mccd_pkg::S_IDLE:
        c_we = in_acc && (coin_count < CntW'(mccd_pkg::MaxCoins));
      mccd_pkg::S_SA:  c_raddr = a;
      mccd_pkg::S_SB:  c_raddr = b;
      mccd_pkg::S_SW1: begin
        c_we = 1'b1; c_waddr = a; c_wdata = bestval;
      end
      mccd_pkg::S_SW2: begin
        c_we = 1'b1; c_waddr = best; c_wdata = aval;
      end
      mccd_pkg::S_FCW: begin
        t_we = 1'b1; t_waddr = {r, SumW'(0)}; t_wdata = '0;
      end
      mccd_pkg::S_FRD, mccd_pkg::S_FWR: begin
        t_raddr_a = {r - IdxW'(1), s};
        t_we      = (state == mccd_pkg::S_FWR);
      end
      mccd_pkg::S_CHK, mccd_pkg::S_CHKW:
        t_raddr_a = {IdxW'(n - CntW'(1)), target_sum};
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mccd_pkg::S_IDLE;
      coin_count <= '0;
      target_sum <= SumW'(1);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) target_sum <= cfg_data;
      if (in_acc) coin_count <= in_data.last_coin ? '0 : n_load;
      if (out_ready) out_valid <= 1'b0;
      if ((state == mccd_pkg::S_NF && out_free) ||
          (state == mccd_pkg::S_WDEC && take_ok && out_free))
        out_valid <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mccd_pkg::S_IDLE: begin
        n <= n_load; a <= '0; r <= '0;
      end
      mccd_pkg::S_SAW: begin
        aval <= c_rdata; bestval <= c_rdata; best <= a; b <= a + IdxW'(1);
      end
      mccd_pkg::S_SBW: begin
        if (c_rdata < bestval) begin
          bestval <= c_rdata; best <= b;
        end
        b <= b + IdxW'(1);
      end
      mccd_pkg::S_SW2: a <= a + IdxW'(1);
      mccd_pkg::S_FCW: begin
        c <= c_rdata; s <= SumW'(1);
      end
      mccd_pkg::S_FWR:
        if (s != target_sum) s <= s + SumW'(1);
        else r <= r + IdxW'(1);
      mccd_pkg::S_CHKW: begin
        r <= IdxW'(n - CntW'(1)); s <= target_sum;
      end
      mccd_pkg::S_WCW: c <= c_rdata;
      mccd_pkg::S_WDEC:
        if (take_ok) begin
          if (out_free) begin
            s <= s_rem;
            out_data.chosen_value <= c;
            out_data.found        <= 1'b1;
            out_data.last_result  <= (s_rem == '0);
          end
        end else begin
          r <= r - IdxW'(1);
        end
      mccd_pkg::S_NF:
        if (out_free) begin
          out_data.chosen_value <= '0;
          out_data.found        <= 1'b0;
          out_data.last_result  <= 1'b1;
        end
      default: ;
    endcase
  end

  // a not-found word always closes its run
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.last_result)
    else $error("not-found word without last mark");

  // a found word carries a usable coin
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.chosen_value != '0)
    else $error("found word with zero coin");

  // the coin count never passes the store depth
  assert property (@(posedge clk) disable iff (rst)
    coin_count <= CntW'(mccd_pkg::MaxCoins))
    else $error("coin count overflow");

  // the sort scan index stays inside the loaded set
  assert property (@(posedge clk) disable iff (rst)
    state == mccd_pkg::S_SBW |-> {1'b0, b} < n)
    else $error("sort scan out of range");

  // a stalled out word stays valid until it is taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !$rose(out_valid) && out_valid)
    else $error("out word lost");
endmodule

### hw/rtl/mccd_coin_ram.sv
// Coin store: single write port, single registered read port.
// Depends on mccd_pkg.
module mccd_coin_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [mccd_pkg::IdxW-1:0]     waddr,
  input  logic [mccd_pkg::CoinW-1:0]    wdata,
  input  logic [mccd_pkg::IdxW-1:0]     raddr,
  output logic [mccd_pkg::CoinW-1:0]    rdata
);
  logic [mccd_pkg::CoinW-1:0] mem [mccd_pkg::MaxCoins];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/mccd_table_ram.sv
// Count table: one write port and two registered read ports.
// Depends on mccd_pkg.
module mccd_table_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [mccd_pkg::TabAddrW-1:0]   waddr,
  input  logic [mccd_pkg::TabW-1:0]       wdata,
  input  logic [mccd_pkg::TabAddrW-1:0]   raddr_a,
  output logic [mccd_pkg::TabW-1:0]       rdata_a,
  input  logic [mccd_pkg::TabAddrW-1:0]   raddr_b,
  output logic [mccd_pkg::TabW-1:0]       rdata_b
);
  logic [mccd_pkg::TabW-1:0] mem [2**mccd_pkg::TabAddrW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

### sim/min_coin_change_dp_tb.sv
`timescale 1ns / 1ps
// Testbench for min_coin_change_dp: random coin sets and target sums checked
// against a built-in minimum-coin predictor. Depends on mccd_pkg and the RTL.
module min_coin_change_dp_tb;

  localparam int WatchLimit = 400000;
  localparam int CoinW = mccd_pkg::CoinW;
  localparam int SumW = mccd_pkg::SumW;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  mccd_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mccd_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [SumW-1:0] cfg_data = '0;

  min_coin_change_dp i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [CoinW-1:0] coin_set[mccd_pkg::MaxCoins];
  int unsigned set_len;
  logic [SumW-1:0] goal_sum;
  mccd_pkg::out_word_t answer_q[$];
  mccd_pkg::in_word_t word_q[$];
  int err_cnt;
  int sent_cnt, got_cnt, set_cnt, miss_cnt;
  int idle_cycles;
  bit running;
  int gap_in, gap_out;

  function automatic int rand_gap();
    int g;
    g = 0;
    if ($urandom_range(0, 3) == 0) g = $urandom_range(1, 3);
    if ($urandom_range(0, 40) == 0) g = $urandom_range(10, 60);
    return g;
  endfunction

  function automatic int next_cost(logic [CoinW-1:0] c, int s, int v);
    if (c == 0 || c > s || v >= mccd_pkg::CountInf) return mccd_pkg::CountInf;
    return v + 1;
  endfunction

  // fewest-coins table, then walk back from the largest coin
  task automatic solve_set();
    logic [CoinW-1:0] srt[mccd_pkg::MaxCoins];
    logic [CoinW-1:0] tmp;
    int tab[mccd_pkg::MaxCoins][mccd_pkg::MaxSum+1];
    int n, t, best, skip, tk, r, s, k;
    mccd_pkg::out_word_t w;
    n = set_len;
    t = goal_sum;
    set_len = 0;
    set_cnt++;
    if (n == 0 || t == 0) begin
      w = '{chosen_value: '0, found: 1'b0, last_result: 1'b1};
      answer_q.insert(answer_q.size(), w);
      miss_cnt++;
      return;
    end
    for (int a = 0; a < n; a++) srt[a] = coin_set[a];
    for (int a = 0; a + 1 < n; a++) begin
      best = a;
      for (int b = a + 1; b < n; b++) if (srt[b] < srt[best]) best = b;
      tmp = srt[a]; srt[a] = srt[best]; srt[best] = tmp;
    end
    for (int a = 0; a < n; a++) begin
      tab[a][0] = 0;
      for (int b = 1; b <= t; b++) begin
        skip = (a >= 1) ? tab[a-1][b] : mccd_pkg::CountInf;
        tk = (srt[a] != 0 && srt[a] <= b) ? next_cost(srt[a], b, tab[a][b-srt[a]])
                                          : mccd_pkg::CountInf;
        tab[a][b] = (tk < skip) ? tk : skip;
      end
    end
    if (tab[n-1][t] >= mccd_pkg::CountInf) begin
      w = '{chosen_value: '0, found: 1'b0, last_result: 1'b1};
      answer_q.insert(answer_q.size(), w);
      miss_cnt++;
      return;
    end
    r = n - 1; s = t; k = 0;
    while (r >= 0 && s > 0 && k < mccd_pkg::MaxSum) begin
      tk = (srt[r] != 0 && srt[r] <= s) ? next_cost(srt[r], s, tab[r][s-srt[r]])
                                        : mccd_pkg::CountInf;
      if (tk < mccd_pkg::CountInf && tab[r][s] == tk) begin
        w = '{chosen_value: srt[r], found: 1'b1, last_result: 1'b0};
        answer_q.insert(answer_q.size(), w);
        k++;
        s -= srt[r];
      end else begin
        r--;
      end
    end
    if (k == 0) begin
      w = '{chosen_value: '0, found: 1'b0, last_result: 1'b1};
      answer_q.insert(answer_q.size(), w);
      miss_cnt++;
    end else begin
      w = answer_q.pop_back();
      w.last_result = 1'b1;
      answer_q.insert(answer_q.size(), w);
    end
  endtask

  task automatic load_word(mccd_pkg::in_word_t w);
    if (set_len < mccd_pkg::MaxCoins) begin
      coin_set[set_len] = w.coin_value;
      set_len++;
    end
    if (w.last_coin) solve_set();
  endtask

  // driver: feeds word_q while running
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        load_word(in_data);
        sent_cnt++;
      end
      if (in_valid && !in_ready) begin
      end else if (running && word_q.size() > 0 && gap_in == 0) begin
        in_valid <= 1'b1;
        in_data <= word_q.pop_front();
        gap_in <= rand_gap();
      end else begin
        in_valid <= 1'b0;
        if (gap_in > 0) gap_in <= gap_in - 1;
      end
    end
  end

  // monitor: check each result word against the oldest expectation
  always @(posedge clk) begin
    mccd_pkg::out_word_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_cnt++;
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected word chosen=%0d found=%0b last=%0b", $time,
                   out_data.chosen_value, out_data.found, out_data.last_result);
          err_cnt++;
        end else begin
          e = answer_q.pop_front();
          if (out_data !== e) begin
            $display("%0t: mismatch exp chosen=%0d found=%0b last=%0b, got %0d %0b %0b",
                     $time, e.chosen_value, e.found, e.last_result,
                     out_data.chosen_value, out_data.found, out_data.last_result);
            err_cnt++;
          end
        end
      end
      if (gap_out > 0) begin
        out_ready <= 1'b0;
        gap_out <= gap_out - 1;
      end else begin
        out_ready <= 1'b1;
        gap_out <= rand_gap();
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("min_coin_change_dp test failed");
        $finish;
      end
    end
  end

  task automatic add_set(int n, int maxv);
    mccd_pkg::in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.coin_value = CoinW'($urandom_range(1, maxv));
      w.last_coin = (i == n - 1);
      word_q.insert(word_q.size(), w);
    end
  endtask

  task automatic push_word(int v, bit l);
    mccd_pkg::in_word_t w;
    w.coin_value = CoinW'(v);
    w.last_coin = l;
    word_q.insert(word_q.size(), w);
  endtask

  // run queued words until all answers are back, then idle for the tail
  task automatic drain();
    running = 1'b1;
    while (word_q.size() > 0 || in_valid || answer_q.size() > 0) @(posedge clk);
    running = 1'b0;
    repeat (20) @(posedge clk);
  endtask

  task automatic set_goal(int g);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= SumW'(g);
    goal_sum = SumW'(g);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int g;
    err_cnt = 0; sent_cnt = 0; got_cnt = 0; set_cnt = 0; miss_cnt = 0;
    set_len = 0; goal_sum = 1; running = 1'b0;
    gap_in = 0; gap_out = 0; idle_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset target of one, then edge values
    push_word(1, 1'b1);
    push_word(16'hFFFF, 1'b1);
    drain();
    set_goal(63);
    push_word(1, 1'b1);            // longest answer run
    push_word(0, 1'b0); push_word(16'hAAAA, 1'b0); push_word(16'h5555, 1'b1);
    push_word(0, 1'b1);            // zero coin only
    push_word(7, 1'b0); push_word(3, 1'b0); push_word(5, 1'b1);
    drain();
    set_goal(0);
    push_word(2, 1'b1);
    drain();
    set_goal(30);
    // full store: 64 coins then the 65th dropped but still triggers work
    for (int i = 0; i < 64; i++) push_word($urandom_range(4, 200), 1'b0);
    push_word(1, 1'b1);
    push_word(4, 1'b0); push_word(3, 1'b0); push_word(1, 1'b1);
    drain();

    // random sets, target changed between phases
    for (int p = 0; p < 6; p++) begin
      g = (p == 0) ? 1 : (p == 1) ? 63 : $urandom_range(1, 63);
      set_goal(g);
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(0, 3) == 0) add_set($urandom_range(1, 6), 16'hFFFF);
        else add_set($urandom_range(1, 5), 20);
      end
      drain();
    end

    $display("Covered %0d coin words, %0d sets (%0d unreachable), %0d result words.",
             sent_cnt, set_cnt, miss_cnt, got_cnt);
    if (err_cnt == 0) begin
      $display("min_coin_change_dp test passed");
    end else begin
      $display("min_coin_change_dp test failed");
    end
    $finish;
  end

endmodule

### min_coin_change_dp.f
hw/rtl/mccd_pkg.sv
hw/rtl/mccd_coin_ram.sv
hw/rtl/mccd_table_ram.sv
hw/rtl/min_coin_change_dp.sv
sim/min_coin_change_dp_tb.sv
